### rtl/core/rwp_pkg.sv
package rwp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [15:0] FMT_PCM  = 16'h0001;
	localparam logic [31:0] FMT_MIN  = 32'd16;
	localparam logic [31:0] TAG_LEN  = 32'd4;

	typedef enum logic [3:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_ID,
		PH_SIZE,
		PH_FMT,
		PH_DATA,
		PH_SKIP,
		PH_PAD,
		PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_OK,
		ST_BAD_TAG,
		ST_NON_PCM,
		ST_FMT_SHORT,
		ST_TRUNC
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        pay_valid;
		logic [7:0]  pay_data;
		logic        done;
		status_t     status;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] data_len;
	} res_t;

	// Replace one byte lane of a 32-bit word.
	function automatic logic [31:0] put_lane(input logic [31:0] word, input logic [1:0] lane,
		input logic [7:0] b);
		logic [31:0] r;
		r = word;
		case (lane)
			2'd0: r[7:0] = b;
			2'd1: r[15:8] = b;
			2'd2: r[23:16] = b;
			2'd3: r[31:24] = b;
			default: r = word;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/rwp_in_stage.sv
module rwp_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    data,
	input  logic          last,
	input  logic          advance,
	output logic          stall,
	output logic          valid_s1,
	output rwp_pkg::item_t item_s1
);
	import rwp_pkg::*;

	logic accept;

	// Hold the stage while its request cannot move on.
	assign stall  = valid_s1 & ~advance;
	assign accept = in_valid & ~stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data <= data;
			item_s1.last <= last;
		end
	end

endmodule

### rtl/core/rwp_parse.sv
module rwp_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  rwp_pkg::item_t item,
	output rwp_pkg::res_t  res
);
	import rwp_pkg::*;

	phase_t      phase_q, phase_n;
	logic [31:0] cnt_q, cnt_n, cnt_inc;
	logic [31:0] tag_q, tag_n;
	logic [31:0] size_q, size_n;
	logic        pad_q, pad_n;
	status_t     err_q, err_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] dlen_q, dlen_n;
	logic [7:0]  b;

	assign b       = item.data;
	assign cnt_inc = cnt_q + 32'd1;

	// Next state for one byte.
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		tag_n   = tag_q;
		size_n  = size_q;
		pad_n   = pad_q;
		err_n   = err_q;
		chan_n  = chan_q;
		rate_n  = rate_q;
		bits_n  = bits_q;
		dlen_n  = dlen_q;
		case (phase_q)
			PH_RIFF, PH_WAVE, PH_ID: begin
				tag_n = {tag_q[23:0], b};
				cnt_n = cnt_inc;
				if (cnt_inc == TAG_LEN) begin
					cnt_n = '0;
					if (phase_q == PH_ID) begin
						size_n  = '0;
						phase_n = PH_SIZE;
					end else if (phase_q == PH_RIFF) begin
						if (tag_n != TAG_RIFF) begin
							err_n   = ST_BAD_TAG;
							phase_n = PH_HALT;
						end else begin
							phase_n = PH_RSIZE;
						end
					end else begin
						if (tag_n != TAG_WAVE) begin
							err_n   = ST_BAD_TAG;
							phase_n = PH_HALT;
						end else begin
							phase_n = PH_ID;
						end
					end
				end
			end
			PH_RSIZE: begin
				cnt_n = cnt_inc;
				if (cnt_inc == TAG_LEN) begin
					cnt_n   = '0;
					phase_n = PH_WAVE;
				end
			end
			PH_SIZE: begin
				size_n = put_lane(size_q, cnt_q[1:0], b);
				cnt_n  = cnt_inc;
				if (cnt_inc == TAG_LEN) begin
					cnt_n = '0;
					if (tag_q == TAG_FMT) begin
						pad_n = 1'b0;
						if (size_n < FMT_MIN) begin
							err_n   = ST_FMT_SHORT;
							phase_n = PH_HALT;
						end else begin
							phase_n = PH_FMT;
						end
					end else begin
						pad_n = size_n[0];
						if (tag_q == TAG_DATA) begin
							dlen_n  = size_n;
							phase_n = PH_DATA;
						end else begin
							phase_n = PH_SKIP;
						end
						// Empty body: go straight to the pad byte or the next id.
						if (size_n == '0) begin
							phase_n = pad_n ? PH_PAD : PH_ID;
						end
					end
				end
			end
			PH_FMT: begin
				cnt_n = cnt_inc;
				if (cnt_q == 32'd0) begin
					tag_n = {24'd0, b};
				end else if (cnt_q == 32'd1) begin
					tag_n = tag_q | {16'd0, b, 8'd0};
				end else if (cnt_q < 32'd4) begin
					chan_n = cnt_q[0] ? {b, chan_q[7:0]} : {chan_q[15:8], b};
				end else if (cnt_q < 32'd8) begin
					rate_n = put_lane(rate_q, cnt_q[1:0], b);
				end else if (cnt_q == 32'd14 || cnt_q == 32'd15) begin
					bits_n = cnt_q[0] ? {b, bits_q[7:0]} : {bits_q[15:8], b};
				end
				if (cnt_q == 32'd1 && tag_n != {16'd0, FMT_PCM}) begin
					// Non-PCM: halt without advancing the offset.
					err_n   = ST_NON_PCM;
					phase_n = PH_HALT;
					cnt_n   = cnt_q;
				end else if (cnt_inc == size_q) begin
					cnt_n   = '0;
					phase_n = pad_q ? PH_PAD : PH_ID;
				end
			end
			PH_DATA, PH_SKIP: begin
				cnt_n = cnt_inc;
				if (cnt_inc == size_q) begin
					cnt_n   = '0;
					phase_n = pad_q ? PH_PAD : PH_ID;
				end
			end
			PH_PAD: begin
				pad_n   = 1'b0;
				cnt_n   = '0;
				phase_n = PH_ID;
			end
			default: begin
			end
		endcase
	end

	// Result for this byte: payload from the current phase, the rest from the updated state.
	always_comb begin
		res.pay_valid = (phase_q == PH_DATA);
		res.pay_data  = (phase_q == PH_DATA) ? b : 8'd0;
		res.done      = item.last;
		res.status    = ST_RUN;
		if (item.last) begin
			if (err_n != ST_RUN) begin
				res.status = err_n;
			end else if (phase_n == PH_ID && cnt_n == '0) begin
				res.status = ST_OK;
			end else begin
				res.status = ST_TRUNC;
			end
		end
		res.chan     = chan_n;
		res.rate     = rate_n;
		res.bits     = bits_n;
		res.data_len = dlen_n;
	end

	// Advance on each byte; drop everything back to reset after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			cnt_q   <= '0;
			tag_q   <= '0;
			size_q  <= '0;
			pad_q   <= 1'b0;
			err_q   <= ST_RUN;
			chan_q  <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			dlen_q  <= '0;
		end else if (step) begin
			if (item.last) begin
				phase_q <= PH_RIFF;
				cnt_q   <= '0;
				tag_q   <= '0;
				size_q  <= '0;
				pad_q   <= 1'b0;
				err_q   <= ST_RUN;
				chan_q  <= '0;
				rate_q  <= '0;
				bits_q  <= '0;
				dlen_q  <= '0;
			end else begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				tag_q   <= tag_n;
				size_q  <= size_n;
				pad_q   <= pad_n;
				err_q   <= err_n;
				chan_q  <= chan_n;
				rate_q  <= rate_n;
				bits_q  <= bits_n;
				dlen_q  <= dlen_n;
			end
		end
	end

endmodule

### rtl/core/riff_wave_pcm_parser.sv
// An accepted request is held in the input stage, then parsed into the result register.
// Throughput: one byte per cycle while out_stall is low; state steps once per byte.
// Every input byte yields exactly one result; status is nonzero only with done_res.
// Reset: arst_n clears the parser to expect a RIFF tag and empties both stages.
// After a request with last_byte set, the parser returns to that same reset state.
module riff_wave_pcm_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_bytes
);
	import rwp_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  advance;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;

	// Move the held request into the result register whenever that register is
	// empty or being drained this cycle; the parser state steps at the same edge.
	assign advance = valid_s1 & (~out_valid_q | ~out_stall);

	rwp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.data     (byte_in),
		.last     (last_byte),
		.advance  (advance),
		.stall    (in_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Tag checks, little-endian size assembly, fmt capture and payload gating.
	rwp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	// Result register: hold while stalled, drop once taken with nothing behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign payload_valid   = res_q.pay_valid;
	assign payload_byte    = res_q.pay_data;
	assign done_res        = res_q.done;
	assign status          = res_q.status;
	assign channels        = res_q.chan;
	assign sample_rate     = res_q.rate;
	assign bits_per_sample = res_q.bits;
	assign data_bytes      = res_q.data_len;

	// The input stage only stalls while it holds a request.
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stall without a held request");

	// Status is reported only on the final byte of a file.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == ST_RUN)
		else $error("status set before the last byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> status != ST_RUN)
		else $error("last byte without a final status");

	// A result with no audio byte carries a zero byte field.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("payload byte set outside a data chunk");

endmodule

### verif/riff_wave_pcm_parser_test.sv
module riff_wave_pcm_parser_test;

	import rwp_pkg::*;

	// Chunk id of a LIST chunk, used as a chunk that the parser skips.
	localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

	// Shapes of file image that the stimulus builder knows how to write.
	typedef enum logic [3:0] {
		F_NOISE,
		F_BAD_RIFF,
		F_BAD_WAVE,
		F_HDR_ONLY,
		F_FMT_SHORT,
		F_NON_PCM,
		F_PCM,
		F_NOPAD,
		F_SKIP,
		F_ZERO,
		F_REPEAT,
		F_EXTREME,
		F_CUT,
		F_RANDOM
	} file_kind_t;

	// One row of the directed plan: a file shape, its size knob, and the
	// status the parser must report on the final byte.
	typedef struct packed {
		file_kind_t  kind;
		logic [31:0] arg;
		status_t     want;
	} plan_row_t;

	// One byte request, with an optional hand-written status for its result.
	typedef struct packed {
		item_t   it;
		logic    typed;
		status_t want;
	} byte_req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_in;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        done_res;
	logic [2:0]  status;
	logic [15:0] channels;
	logic [31:0] sample_rate;
	logic [15:0] bits_per_sample;
	logic [31:0] data_bytes;

	riff_wave_pcm_parser u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.byte_in         (byte_in),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_valid   (payload_valid),
		.payload_byte    (payload_byte),
		.done_res        (done_res),
		.status          (status),
		.channels        (channels),
		.sample_rate     (sample_rate),
		.bits_per_sample (bits_per_sample),
		.data_bytes      (data_bytes)
	);

	// Directed plan: every error code, clean ends on a tag, a chunk and a pad
	// byte, truncation in a body and before a pad, and the field extremes.
	plan_row_t plan [16] = '{
		'{F_NOISE,     32'd1,  ST_TRUNC},
		'{F_BAD_RIFF,  32'd0,  ST_BAD_TAG},
		'{F_BAD_RIFF,  32'd5,  ST_BAD_TAG},
		'{F_BAD_WAVE,  32'd3,  ST_BAD_TAG},
		'{F_HDR_ONLY,  32'd0,  ST_OK},
		'{F_FMT_SHORT, 32'd0,  ST_FMT_SHORT},
		'{F_FMT_SHORT, 32'd15, ST_FMT_SHORT},
		'{F_NON_PCM,   32'd0,  ST_NON_PCM},
		'{F_PCM,       32'd1,  ST_OK},
		'{F_PCM,       32'd8,  ST_OK},
		'{F_NOPAD,     32'd3,  ST_TRUNC},
		'{F_SKIP,      32'd3,  ST_OK},
		'{F_ZERO,      32'd0,  ST_OK},
		'{F_REPEAT,    32'd0,  ST_OK},
		'{F_EXTREME,   32'd0,  ST_OK},
		'{F_EXTREME,   32'd1,  ST_TRUNC}
	};

	// Parser shadow state.
	phase_t      pstate;
	logic [31:0] pcount;
	logic [31:0] ptag;
	logic [31:0] psize;
	logic        ppad;
	status_t     perr;
	logic [15:0] cap_chan;
	logic [31:0] cap_rate;
	logic [15:0] cap_bits;
	logic [31:0] cap_len;

	logic [7:0] file_img [$];
	byte_req_t  byte_reqs [$];
	res_t       parse_results_q [$];
	byte_req_t  cur_req;
	logic       req_taken;

	int send_idle_pct;
	int recv_stall_pct;
	logic hold_req;
	int fail_count;
	int results_seen;
	int bytes_queued;
	int files_queued;
	int files_ok;
	int files_trunc;
	int files_bad;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hold reset low from time zero, then release it on a falling edge.
	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Abort a hung run.
	initial begin
		#200000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// ------------------------------------------------------------------
	// Parser shadow
	// ------------------------------------------------------------------

	function automatic void clear_parser();
		pstate = PH_RIFF;
		pcount = '0;
		ptag = '0;
		psize = '0;
		ppad = 1'b0;
		perr = ST_RUN;
		cap_chan = '0;
		cap_rate = '0;
		cap_bits = '0;
		cap_len = '0;
	endfunction

	// Stop on the first error; later bytes are ignored until the last one.
	function automatic void halt(input status_t code);
		perr = code;
		pstate = PH_HALT;
	endfunction

	// Close a chunk body; odd data and skipped chunks still owe a pad byte.
	function automatic void finish_body();
		pcount = '0;
		pstate = ppad ? PH_PAD : PH_ID;
	endfunction

	// Advance the shadow by one byte and return the result it must produce.
	function automatic res_t parse_byte(input item_t it);
		res_t r;
		logic [7:0] b;
		b = it.data;
		r = '0;
		case (pstate)
			PH_RIFF, PH_WAVE, PH_ID: begin
				ptag = {ptag[23:0], b};
				pcount++;
				if (pcount == TAG_LEN) begin
					pcount = '0;
					if (pstate == PH_ID) begin
						psize = '0;
						pstate = PH_SIZE;
					end else if (pstate == PH_RIFF) begin
						if (ptag != TAG_RIFF) halt(ST_BAD_TAG);
						else pstate = PH_RSIZE;
					end else begin
						if (ptag != TAG_WAVE) halt(ST_BAD_TAG);
						else pstate = PH_ID;
					end
				end
			end
			PH_RSIZE: begin
				pcount++;
				if (pcount == TAG_LEN) begin
					pcount = '0;
					pstate = PH_WAVE;
				end
			end
			PH_SIZE: begin
				// Sizes arrive little-endian, one lane per byte.
				psize[8*pcount[1:0] +: 8] = b;
				pcount++;
				if (pcount == TAG_LEN) begin
					pcount = '0;
					if (ptag == TAG_FMT) begin
						ppad = 1'b0;
						if (psize < FMT_MIN) halt(ST_FMT_SHORT);
						else pstate = PH_FMT;
					end else begin
						ppad = psize[0];
						if (ptag == TAG_DATA) begin
							cap_len = psize;
							pstate = PH_DATA;
						end else begin
							pstate = PH_SKIP;
						end
						if (psize == 0) finish_body();
					end
				end
			end
			PH_FMT: begin
				if (pcount == 0) ptag = {24'h0, b};
				else if (pcount == 1) ptag[15:8] = b;
				else if (pcount < 4) cap_chan[8*pcount[0] +: 8] = b;
				else if (pcount < 8) cap_rate[8*pcount[1:0] +: 8] = b;
				else if (pcount == 14 || pcount == 15) cap_bits[8*pcount[0] +: 8] = b;
				if (pcount == 1 && ptag != {16'h0, FMT_PCM}) begin
					halt(ST_NON_PCM);
				end else begin
					pcount++;
					if (pcount == psize) finish_body();
				end
			end
			PH_DATA: begin
				r.pay_valid = 1'b1;
				r.pay_data = b;
				pcount++;
				if (pcount == psize) finish_body();
			end
			PH_SKIP: begin
				pcount++;
				if (pcount == psize) finish_body();
			end
			PH_PAD: begin
				ppad = 1'b0;
				pcount = '0;
				pstate = PH_ID;
			end
			default: begin
			end
		endcase
		r.done = it.last;
		r.status = ST_RUN;
		if (it.last) begin
			if (perr != ST_RUN) r.status = perr;
			else if (pstate == PH_ID && pcount == 0) r.status = ST_OK;
			else r.status = ST_TRUNC;
		end
		r.chan = cap_chan;
		r.rate = cap_rate;
		r.bits = cap_bits;
		r.data_len = cap_len;
		// Re-arm for the next file after its final byte.
		if (it.last) clear_parser();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// File image builder
	// ------------------------------------------------------------------

	// Chunk ids go out most significant byte first.
	task automatic put_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--) file_img.push_back(t[8*i +: 8]);
	endtask

	task automatic put_le32(input logic [31:0] v);
		for (int i = 0; i < 4; i++) file_img.push_back(v[8*i +: 8]);
	endtask

	task automatic put_random(input int n);
		repeat (n) file_img.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_header();
		put_tag(TAG_RIFF);
		put_random(4);
		put_tag(TAG_WAVE);
	endtask

	// Write an fmt chunk of the given declared size; fields past the size are
	// dropped, and bytes past sixteen are filler. No pad byte follows.
	task automatic put_fmt(input logic [31:0] size, input logic [15:0] ftag,
		input logic [15:0] chan, input logic [31:0] rate, input logic [15:0] bits);
		logic [127:0] fbody;
		fbody = {bits, $urandom, 16'($urandom), rate, chan, ftag};
		put_tag(TAG_FMT);
		put_le32(size);
		for (int unsigned i = 0; i < size; i++) begin
			if (i < 16) file_img.push_back(fbody[8*i +: 8]);
			else put_random(1);
		end
	endtask

	// Write a chunk header and n body bytes; add the pad byte when the whole
	// odd-sized body is present.
	task automatic put_body(input logic [31:0] tag, input logic [31:0] size, input int n);
		put_tag(tag);
		put_le32(size);
		put_random(n);
		if (n == size && size[0]) put_random(1);
	endtask

	task automatic build_file(input file_kind_t kind, input logic [31:0] arg);
		int r;
		int n;
		int len;
		int idx;
		bit cut;
		file_img.delete();
		case (kind)
			F_NOISE: put_random(arg);
			F_BAD_RIFF: begin
				put_tag(TAG_RIFF ^ 32'h1E);
				put_random(arg);
			end
			F_BAD_WAVE: begin
				put_tag(TAG_RIFF);
				put_random(4);
				put_tag(TAG_WAVE ^ 32'h1);
				put_random(arg);
			end
			F_HDR_ONLY: put_header();
			F_FMT_SHORT: begin
				// Bytes after the short size must be ignored.
				put_header();
				put_fmt(arg, FMT_PCM, 16'd2, 32'd48000, 16'd16);
				put_body(TAG_DATA, 32'd4, 4);
			end
			F_NON_PCM: begin
				put_header();
				put_fmt(32'd16, 16'h0003, 16'd2, 32'd44100, 16'd32);
				put_body(TAG_DATA, 32'd2, 2);
			end
			F_PCM, F_NOPAD, F_CUT: begin
				put_header();
				put_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, 16'd8);
				put_body(TAG_DATA, (kind == F_CUT) ? 32'd4 : arg, (kind == F_CUT) ? 4 : arg);
				// Drop the pad byte, or cut the image short.
				if (kind == F_NOPAD) void'(file_img.pop_back());
				if (kind == F_CUT) while (file_img.size() > arg) void'(file_img.pop_back());
			end
			F_SKIP: begin
				put_header();
				put_body(TAG_LIST, arg, arg);
				put_fmt(32'd16, FMT_PCM, 16'd2, 32'd22050, 16'd16);
				put_body(TAG_DATA, 32'd2, 2);
			end
			F_ZERO: begin
				put_header();
				put_body(TAG_DATA, 32'd0, 0);
				put_body(TAG_LIST, 32'd0, 0);
			end
			F_REPEAT: begin
				// The second fmt overwrites what the first one captured.
				put_header();
				put_fmt(32'd16, FMT_PCM, 16'd2, 32'd44100, 16'd16);
				put_body(TAG_DATA, 32'd3, 3);
				put_fmt(32'd20, FMT_PCM, 16'd6, 32'd96000, 16'd24);
				put_body(TAG_DATA, 32'd2, 2);
			end
			F_EXTREME: begin
				put_header();
				if (arg == 0) begin
					put_fmt(32'd16, FMT_PCM, 16'h0, 32'h0, 16'h0);
					put_body(TAG_DATA, 32'd0, 0);
				end else begin
					put_fmt(32'd18, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
					put_body(TAG_DATA, 32'hFFFF_FFFF, 5);
				end
			end
			default: begin
				// Well-formed chunk sequence with random content, then damage a
				// share of the files.
				put_header();
				n = $urandom_range(1, 4);
				cut = 1'b0;
				for (int c = 0; c < n && !cut; c++) begin
					r = $urandom_range(0, 19);
					if (r < 7) begin
						put_fmt((r == 0) ? $urandom_range(0, 15) : $urandom_range(16, 22),
							(r == 1) ? 16'($urandom) : FMT_PCM,
							16'($urandom), $urandom, 16'($urandom));
					end else if (r < 14) begin
						len = $urandom_range(0, 24);
						put_body(TAG_DATA, len, len);
					end else if (r < 18) begin
						len = $urandom_range(0, 9);
						put_body($urandom, len, len);
					end else begin
						// Huge declared size: send a few bytes and end the file.
						put_body((r == 18) ? TAG_DATA : $urandom, $urandom, $urandom_range(0, 6));
						cut = 1'b1;
					end
				end
				r = $urandom_range(0, 99);
				if (r < 12) begin
					len = $urandom_range(1, file_img.size());
					while (file_img.size() > len) void'(file_img.pop_back());
				end else if (r < 18) begin
					idx = $urandom_range(0, file_img.size() - 1);
					file_img[idx] = file_img[idx] ^ (8'h1 << $urandom_range(0, 7));
				end
			end
		endcase
	endtask

	// Turn the image into byte requests; the final byte carries last_byte.
	task automatic queue_image(input logic typed, input status_t want);
		byte_req_t rq;
		foreach (file_img[i]) begin
			rq.it.data = file_img[i];
			rq.it.last = (i == file_img.size() - 1);
			rq.typed = typed && rq.it.last;
			rq.want = want;
			byte_reqs.push_back(rq);
		end
		bytes_queued += file_img.size();
		files_queued++;
	endtask

	// Keep the request queue short so idle settings apply promptly.
	task automatic throttle();
		while (byte_reqs.size() > 32) @(negedge clk);
	endtask

	// Pause the sender until every request is through and every result is out.
	task automatic drain();
		while (byte_reqs.size() != 0 || in_valid || parse_results_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Drive requests on falling edges; advance only after an accepted request.
	initial begin : feed_bytes
		in_valid = 1'b0;
		byte_in = '0;
		last_byte = 1'b0;
		cur_req = '0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!in_valid || req_taken) begin
				if (byte_reqs.size() != 0 && !roll(send_idle_pct)) begin
					cur_req = byte_reqs.pop_front();
					byte_in = cur_req.it.data;
					last_byte = cur_req.it.last;
					in_valid = 1'b1;
				end else begin
					in_valid = 1'b0;
				end
			end
		end
	end

	// Drive stall on falling edges; a long hold-off is counted out here.
	initial begin : pace_results
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				out_stall = roll(recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic bit same(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// On each rising edge: check an accepted result against the oldest
	// prediction first, then predict for the request accepted at this edge.
	always @(posedge clk) begin : watch_ports
		res_t want;
		bit ok;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (parse_results_q.size() == 0) begin
					$display("%0t: result with nothing pending, expected none, got status %0d payload %0h",
						$time, status, payload_byte);
					fail_count++;
				end else begin
					want = parse_results_q.pop_front();
					ok = same("payload_valid", 32'(want.pay_valid), 32'(payload_valid));
					ok = same("payload_byte", 32'(want.pay_data), 32'(payload_byte)) & ok;
					ok = same("done_res", 32'(want.done), 32'(done_res)) & ok;
					ok = same("status", 32'(want.status), 32'(status)) & ok;
					ok = same("channels", 32'(want.chan), 32'(channels)) & ok;
					ok = same("sample_rate", want.rate, sample_rate) & ok;
					ok = same("bits_per_sample", 32'(want.bits), 32'(bits_per_sample)) & ok;
					ok = same("data_bytes", want.data_len, data_bytes) & ok;
					if (!ok) fail_count++;
				end
			end
			req_taken = in_valid && !in_stall;
			if (req_taken) begin
				want = parse_byte(cur_req.it);
				if (cur_req.typed) want.status = cur_req.want;
				if (want.done) begin
					if (want.status == ST_OK) files_ok++;
					else if (want.status == ST_TRUNC) files_trunc++;
					else files_bad++;
				end
				parse_results_q.push_back(want);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : run_plan
		int phase_start;
		req_taken = 1'b0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		results_seen = 0;
		bytes_queued = 0;
		files_queued = 0;
		files_ok = 0;
		files_trunc = 0;
		files_bad = 0;
		clear_parser();
		wait (arst_n);

		// Directed files, back to back, with no idling.
		foreach (plan[i]) begin
			build_file(plan[i].kind, plan[i].arg);
			queue_image(1'b1, plan[i].want);
			throttle();
		end
		drain();

		// Random files under four idle patterns; drain between patterns.
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					// Hold off the receiver so the parser backs up its input.
					hold_req = 1'b1;
				end
				1: begin
					send_idle_pct = 46;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 46;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			phase_start = bytes_queued;
			while (bytes_queued - phase_start < 180) begin
				if (roll(8)) build_file(F_NOISE, $urandom_range(1, 16));
				else build_file(F_RANDOM, 32'd0);
				queue_image(1'b0, ST_RUN);
				throttle();
			end
			drain();
		end

		// Let any stray result surface before the verdict.
		repeat (10) @(negedge clk);
		$display("Checked %0d results for %0d byte requests in %0d files",
			results_seen, bytes_queued, files_queued);
		$display("Files ending clean: %0d, rejected: %0d, truncated: %0d",
			files_ok, files_bad, files_trunc);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
